>>> rtl/bisr_pkg.sv
package bisr_pkg;

    // Configuration register indexes, in the order of the register list.
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_WIDTH_LOG2 = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BANK_COUNT_LOG2 = 4'd1;

    // Reset values of the bank word width and bank count, and legal range of the bank word width.
    localparam logic [2:0] BANK_WIDTH_LOG2_RESET = 3'd3;
    localparam logic [2:0] BANK_COUNT_LOG2_RESET = 3'd2;
    localparam logic [2:0] BANK_WIDTH_LOG2_MIN   = 3'd3;
    localparam logic [2:0] BANK_WIDTH_LOG2_MAX   = 3'd6;

    // One request word.
    typedef struct packed {
        logic [31:0] start_address;
        logic [8:0]  byte_count;
        logic        write_flag;
        logic [3:0]  atomic_opcode;
    } t_req;

    // One chunk word.
    typedef struct packed {
        logic [4:0]  bank_number;
        logic [31:0] bank_address;
        logic [6:0]  chunk_bytes;
        logic [7:0]  data_offset;
        logic        chunk_write;
        logic [3:0]  chunk_opcode;
        logic        last_chunk;
    } t_chunk;

    // One configuration write word.
    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             value;
    } t_cfg_wr;

endpackage

>>> rtl/bisr_stream_if.sv
// Valid/ready channel carrying one word of type T.
interface bisr_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/bank_interleave_request_splitter.sv
// The first chunk of a request is loaded in the run state after acceptance and offered from
// the output register. The shared chunk unit (offset, size, bank and address logic) gives
// one chunk per cycle while the output is not stalled; the input takes no new request until
// the last chunk is loaded. A waiting chunk stalls the chunk unit, not the next acceptance.
// Reset (synchronous, active low) idles the sequencer, empties the output register and sets
// the word width to 8 bytes and the bank count to 4.
module bank_interleave_request_splitter #(
    parameter int ADDR_BITS         = 32,
    parameter int MAX_BANKS_LOG2    = 5,
    parameter int MAX_REQUEST_BYTES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bisr_stream_if.sink   i_cfg,
    bisr_stream_if.sink   i_req,
    bisr_stream_if.source o_chunk
);

    localparam logic [2:0] CountLog2Max = 3'(MAX_BANKS_LOG2);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                  r_state, n_state;
    logic [2:0]              r_bank_width_log2, n_bank_width_log2;
    logic [2:0]              r_bank_count_log2, n_bank_count_log2;
    logic [ADDR_BITS-1:0]    r_addr, n_addr;
    logic [8:0]              r_remaining, n_remaining;
    logic [7:0]              r_consumed, n_consumed;
    logic                    r_write, n_write;
    logic [3:0]              r_opcode, n_opcode;
    logic                    r_out_valid, n_out_valid;
    bisr_pkg::t_chunk        r_out, n_out;

    bisr_pkg::t_req          req;
    bisr_pkg::t_cfg_wr       cfg;
    logic [8:0]              sat_count;
    logic [2:0]              wbits;
    logic [2:0]              cbits;
    logic [3:0]              total_bits;
    logic [6:0]              word_size;
    logic [6:0]              word_offset;
    logic [6:0]              to_word_end;
    logic [6:0]              chunk_size;
    logic                    is_last;
    logic [ADDR_BITS-1:0]    bank_full;
    logic [ADDR_BITS-1:0]    bank_addr_full;
    logic                    out_free;
    logic                    chunk_load;

    assign req = i_req.data;
    assign cfg = i_cfg.data;

    // Config writes always taken; the user, not the block, keeps it idle when they come.
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_chunk.valid = r_out_valid;
    assign o_chunk.data  = r_out;

    // Request size saturates at the largest request the block supports.
    always_comb begin
        if (32'(req.byte_count) > MAX_REQUEST_BYTES) begin
            sat_count = 9'(MAX_REQUEST_BYTES);
        end else begin
            sat_count = req.byte_count;
        end
    end

    // Register values are clamped to their legal range at the point of use.
    always_comb begin
        priority if (r_bank_width_log2 < bisr_pkg::BANK_WIDTH_LOG2_MIN) begin
            wbits = bisr_pkg::BANK_WIDTH_LOG2_MIN;
        end else if (r_bank_width_log2 > bisr_pkg::BANK_WIDTH_LOG2_MAX) begin
            wbits = bisr_pkg::BANK_WIDTH_LOG2_MAX;
        end else begin
            wbits = r_bank_width_log2;
        end
        if (r_bank_count_log2 > CountLog2Max) begin
            cbits = CountLog2Max;
        end else begin
            cbits = r_bank_count_log2;
        end
    end

    // Chunk unit: size up to the end of the bank word, bank number and in-bank address.
    always_comb begin
        total_bits  = {1'b0, wbits} + {1'b0, cbits};
        word_size   = 7'd1 << wbits;
        word_offset = {1'b0, r_addr[5:0]} & (word_size - 7'd1);
        to_word_end = word_size - word_offset;
        if ({2'b00, to_word_end} > r_remaining) begin
            chunk_size = r_remaining[6:0];
        end else begin
            chunk_size = to_word_end;
        end
        is_last        = ({2'b00, chunk_size} == r_remaining);
        bank_full      = (r_addr >> wbits)
                       & ((ADDR_BITS'(1) << cbits) - ADDR_BITS'(1));
        bank_addr_full = ((r_addr >> total_bits) << wbits)
                       | ADDR_BITS'(word_offset);
    end

    // The output register frees up when empty or when its word is taken this cycle.
    assign out_free   = !r_out_valid || o_chunk.ready;
    assign chunk_load = (r_state == S_RUN) && out_free;

    // Sequencer next-state logic.
    always_comb begin
        n_state           = r_state;
        n_bank_width_log2 = r_bank_width_log2;
        n_bank_count_log2 = r_bank_count_log2;
        n_addr            = r_addr;
        n_remaining       = r_remaining;
        n_consumed        = r_consumed;
        n_write           = r_write;
        n_opcode          = r_opcode;
        n_out_valid       = r_out_valid;
        n_out             = r_out;

        // Register writes; unknown indexes are ignored.
        if (i_cfg.valid) begin
            if (cfg.index == bisr_pkg::CFG_BANK_WIDTH_LOG2) begin
                n_bank_width_log2 = cfg.value[2:0];
            end else if (cfg.index == bisr_pkg::CFG_BANK_COUNT_LOG2) begin
                n_bank_count_log2 = cfg.value[2:0];
            end
        end

        if (o_chunk.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_addr      = ADDR_BITS'(req.start_address);
                    n_remaining = sat_count;
                    n_consumed  = 8'd0;
                    n_write     = req.write_flag;
                    n_opcode    = req.atomic_opcode;
                    if (sat_count != 9'd0) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (chunk_load) begin
                    n_out_valid        = 1'b1;
                    n_out.bank_number  = 5'(bank_full);
                    n_out.bank_address = 32'(bank_addr_full);
                    n_out.chunk_bytes  = chunk_size;
                    n_out.data_offset  = r_consumed;
                    n_out.chunk_write  = r_write;
                    n_out.chunk_opcode = r_opcode;
                    n_out.last_chunk   = is_last;
                    n_addr             = r_addr + ADDR_BITS'(chunk_size);
                    n_remaining        = r_remaining - {2'b00, chunk_size};
                    n_consumed         = r_consumed + {1'b0, chunk_size};
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_out_valid       <= 1'b0;
            r_bank_width_log2 <= bisr_pkg::BANK_WIDTH_LOG2_RESET;
            r_bank_count_log2 <= bisr_pkg::BANK_COUNT_LOG2_RESET;
            r_addr            <= '0;
            r_remaining       <= '0;
            r_consumed        <= '0;
            r_write           <= 1'b0;
            r_opcode          <= '0;
            r_out             <= '0;
        end else begin
            r_state           <= n_state;
            r_out_valid       <= n_out_valid;
            r_bank_width_log2 <= n_bank_width_log2;
            r_bank_count_log2 <= n_bank_count_log2;
            r_addr            <= n_addr;
            r_remaining       <= n_remaining;
            r_consumed        <= n_consumed;
            r_write           <= n_write;
            r_opcode          <= n_opcode;
            r_out             <= n_out;
        end
    end

    // A request with bytes to move always starts the sequencer.
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && sat_count != 9'd0) |=> (r_state == S_RUN))
        else $error("request with bytes did not start the sequencer");

    // While running there are always bytes left.
    a_run_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_remaining != 9'd0))
        else $error("sequencer running with nothing left");

    // Loading the final chunk returns the sequencer to idle with nothing left.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chunk_load && is_last) |=> (r_state == S_IDLE && r_remaining == 9'd0))
        else $error("final chunk did not end the request");

    // A loaded chunk is never empty and never runs past the bank word.
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chunk_load |-> (chunk_size != 7'd0 && chunk_size <= to_word_end))
        else $error("chunk size out of range");

    // The output word is replaced only when free.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_chunk.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled chunk was overwritten");

endmodule
